// File: rtl/core/fmlm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fmlm_pkg
// Shared types and constants for the free-memory level monitor.
// ---------------------------------------------------------------------------
package fmlm_pkg;

   // Word widths of the sample and of the signed differences.
   localparam int DATA_W = 32;
   localparam int DIFF_W = 33;

   // Default geometry: history depth and the sample index of the reference.
   localparam int WINDOW_DEPTH_DEF    = 5;
   localparam int REFERENCE_POINT_DEF = 7;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WARNING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DANGER  = 2'd1;

   // Threshold values after reset.
   localparam logic [DATA_W-1:0] WARNING_RESET = 32'd32768;
   localparam logic [DATA_W-1:0] DANGER_RESET  = 32'd65536;

   // Alarm level codes.
   localparam int LEVEL_W = 2;
   localparam logic [LEVEL_W-1:0] LEVEL_NORMAL  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_WARNING = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_DANGER  = 2'd2;

   // Per-item results of the tracking stage that travel down the pipeline.
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [DATA_W-1:0]  usage;
      logic [DIFF_W-1:0]  change;
      logic [DATA_W-1:0]  lowest;
      logic [DATA_W-1:0]  highest;
      logic               full;
      logic               capture;
   } trk_type;

endpackage
`default_nettype wire

// File: rtl/core/fmlm_track.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fmlm_track
// Sample tracker: peak and floor, sample history with a running sum, sample
// count, usage grading and sample-to-sample change. One item per cycle while advance is high.
// ---------------------------------------------------------------------------
module fmlm_track
   import fmlm_pkg::*;
#(
   parameter int WINDOW_DEPTH    = WINDOW_DEPTH_DEF,
   parameter int REFERENCE_POINT = REFERENCE_POINT_DEF,
   parameter int SUM_W           = DATA_W + $clog2(WINDOW_DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [DATA_W-1:0] sample,
   input  wire logic [DATA_W-1:0] warning_threshold,
   input  wire logic [DATA_W-1:0] danger_threshold,
   output trk_type                trk_ff,
   output logic [SUM_W-1:0]       sum_ff
);

   localparam int COUNT_CAP = ((WINDOW_DEPTH > REFERENCE_POINT) ? WINDOW_DEPTH
                                                                : REFERENCE_POINT) + 1;
   localparam int CNT_W = $clog2(COUNT_CAP + 1);

   logic [DATA_W-1:0] window_ff [WINDOW_DEPTH];
   logic [SUM_W-1:0]  window_sum_ff;
   logic [SUM_W-1:0]  window_sum_in;
   logic [SUM_W-1:0]  sum_in;
   logic [DATA_W-1:0] peak_ff;
   logic [DATA_W-1:0] peak_in;
   logic [DATA_W-1:0] floor_ff;
   logic [DATA_W-1:0] floor_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [DATA_W-1:0] usage;
   logic              full;
   trk_type           trk_in;

   // Extremes after this sample; a stored floor of zero counts as empty.
   always_comb begin
      peak_in  = (sample > peak_ff) ? sample : peak_ff;
      floor_in = ((sample < floor_ff) || (floor_ff == '0)) ? sample : floor_ff;
   end

   // Sum of this sample and the stored history; the oldest entry drops out.
   always_comb begin
      sum_in        = window_sum_ff + SUM_W'(sample);
      window_sum_in = sum_in - SUM_W'(window_ff[WINDOW_DEPTH-1]);
   end

   // Sample count saturates once both the window and the reference are past.
   always_comb begin
      count_in = (count_ff < CNT_W'(COUNT_CAP)) ? count_ff + 1'b1 : count_ff;
      full     = (count_ff > CNT_W'(WINDOW_DEPTH));
   end

   // Usage grading: the danger test wins over the warning test.
   always_comb begin
      usage          = peak_in - sample;
      trk_in.usage   = usage;
      if (usage > danger_threshold) begin
         trk_in.level = LEVEL_DANGER;
      end else if (usage > warning_threshold) begin
         trk_in.level = LEVEL_WARNING;
      end else begin
         trk_in.level = LEVEL_NORMAL;
      end
      trk_in.change  = full ? ({1'b0, sample} - {1'b0, window_ff[0]}) : '0;
      trk_in.lowest  = floor_in;
      trk_in.highest = peak_in;
      trk_in.full    = full;
      trk_in.capture = (count_ff == CNT_W'(REFERENCE_POINT));
   end

   // State and the stage register both move on each processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         window_sum_ff <= '0;
         peak_ff       <= '0;
         floor_ff      <= '0;
         count_ff      <= '0;
      end else if (advance) begin
         for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
            window_ff[i] <= window_ff[i-1];
         end
         window_ff[0]  <= sample;
         window_sum_ff <= window_sum_in;
         peak_ff       <= peak_in;
         floor_ff      <= floor_in;
         count_ff      <= count_in;
      end
   end

   // Stage register toward the averaging pipeline.
   always_ff @(posedge clock) begin
      if (advance) begin
         trk_ff <= trk_in;
         sum_ff <= sum_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/fmlm_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fmlm_div
// Division of the window sum by a constant, as a multiplication by a rounded
// up reciprocal. The product is formed as two registered partial products.
// ---------------------------------------------------------------------------
module fmlm_div
   import fmlm_pkg::*;
#(
   parameter int DIVISOR = WINDOW_DEPTH_DEF + 1,
   parameter int SUM_W   = DATA_W + $clog2(WINDOW_DEPTH_DEF + 1)
) (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [SUM_W-1:0]  sum,
   output logic      [DATA_W-1:0] quotient
);

   // Exact for every sum below 2**SUM_W with a shift of SUM_W plus ceil(log2 D).
   localparam int SHIFT = SUM_W + $clog2(DIVISOR);
   localparam int MW    = SUM_W + 1;
   localparam int LO_W  = SUM_W / 2;
   localparam int HI_W  = SUM_W - LO_W;
   localparam int PW    = SUM_W + MW;
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   logic [LO_W+MW-1:0] lo_ff;
   logic [HI_W+MW-1:0] hi_ff;
   logic [PW-1:0]      product;

   // Partial products of the low and high halves of the sum.
   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff <= (LO_W+MW)'(sum[LO_W-1:0]) * (LO_W+MW)'(RECIP);
         hi_ff <= (HI_W+MW)'(sum[SUM_W-1:LO_W]) * (HI_W+MW)'(RECIP);
      end
   end

   // Recombine and take the integer part.
   always_comb begin
      product  = (PW'(hi_ff) << LO_W) + PW'(lo_ff);
      quotient = product[SHIFT +: DATA_W];
   end

endmodule
`default_nettype wire

// File: rtl/core/free_memory_level_monitor_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// free_memory_level_monitor_core
// Free-memory level monitor: peak, floor, moving average, drift and alarm.
// ---------------------------------------------------------------------------
// Takes one free-memory sample per cycle and returns one result per sample
// while the output is not stalled. A sample passes through an input register,
// the tracking stage (extremes, history, running sum, usage grading), the
// first half of the divide-by-constant multiply, and the result register that
// also freezes the reference average. Sustained throughput is one item per
// clock while the output is not stalled, set by the state update in the
// tracking stage. Thresholds are written through the csr_ port, which is
// always ready; write them only while no item is in flight.
// ---------------------------------------------------------------------------
module free_memory_level_monitor_core
   import fmlm_pkg::*;
#(
   parameter int WINDOW_DEPTH    = WINDOW_DEPTH_DEF,
   parameter int REFERENCE_POINT = REFERENCE_POINT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Sample input.
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [DATA_W-1:0]    req_free_bytes,
   // Results.
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [LEVEL_W-1:0]        rsp_alarm_level,
   output logic [DATA_W-1:0]         rsp_usage_bytes,
   output logic [DATA_W-1:0]         rsp_window_average,
   output logic signed [DIFF_W-1:0]  rsp_drift_from_reference,
   output logic signed [DIFF_W-1:0]  rsp_last_change,
   output logic [DATA_W-1:0]         rsp_lowest_seen,
   output logic [DATA_W-1:0]         rsp_highest_seen,
   // Configuration writes.
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata
);

   localparam int SUM_W = DATA_W + $clog2(WINDOW_DEPTH + 1);

   logic              in_valid_ff;
   logic [DATA_W-1:0] in_sample_ff;
   logic              trk_valid_ff;
   logic              mul_valid_ff;
   logic              trk_ready;
   logic              mul_ready;
   logic              out_ready;
   logic              adv_trk;
   logic              adv_mul;
   logic              adv_out;
   logic [DATA_W-1:0] warning_ff;
   logic [DATA_W-1:0] danger_ff;
   logic [DATA_W-1:0] reference_ff;
   trk_type           trk1;
   trk_type           trk2_ff;
   logic [SUM_W-1:0]  sum1;
   logic [DATA_W-1:0] quotient;
   logic [DATA_W-1:0] avg_in;
   logic [DATA_W-1:0] ref_in;

   // Stage readiness: a stage takes an item when it is empty or drains.
   always_comb begin
      out_ready = !rsp_valid || rsp_ready;
      mul_ready = !mul_valid_ff || out_ready;
      trk_ready = !trk_valid_ff || mul_ready;
      req_ready = !in_valid_ff || trk_ready;
      adv_trk   = in_valid_ff && trk_ready;
      adv_mul   = trk_valid_ff && mul_ready;
      adv_out   = mul_valid_ff && out_ready;
      csr_ready = 1'b1;
   end

   // Occupancy of each stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         trk_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid    <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (trk_ready) begin
            trk_valid_ff <= in_valid_ff;
         end
         if (mul_ready) begin
            mul_valid_ff <= trk_valid_ff;
         end
         if (out_ready) begin
            rsp_valid <= mul_valid_ff;
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff <= req_free_bytes;
      end
   end

   // Threshold registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         warning_ff <= WARNING_RESET;
         danger_ff  <= DANGER_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WARNING: warning_ff <= csr_wdata;
            CSR_DANGER:  danger_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   fmlm_track #(
      .WINDOW_DEPTH    (WINDOW_DEPTH),
      .REFERENCE_POINT (REFERENCE_POINT),
      .SUM_W           (SUM_W)
   ) u_track (
      .clock             (clock),
      .reset             (reset),
      .advance           (adv_trk),
      .sample            (in_sample_ff),
      .warning_threshold (warning_ff),
      .danger_threshold  (danger_ff),
      .trk_ff            (trk1),
      .sum_ff            (sum1)
   );

   fmlm_div #(
      .DIVISOR (WINDOW_DEPTH + 1),
      .SUM_W   (SUM_W)
   ) u_div (
      .clock    (clock),
      .load     (adv_mul),
      .sum      (sum1),
      .quotient (quotient)
   );

   // Tracking results ride alongside the partial products.
   always_ff @(posedge clock) begin
      if (adv_mul) begin
         trk2_ff <= trk1;
      end
   end

   // Average is zero until the window is full; the reference freezes once.
   always_comb begin
      avg_in = trk2_ff.full ? quotient : '0;
      ref_in = trk2_ff.capture ? avg_in : reference_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_ff <= '0;
      end else if (adv_out) begin
         reference_ff <= ref_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (adv_out) begin
         rsp_alarm_level          <= trk2_ff.level;
         rsp_usage_bytes          <= trk2_ff.usage;
         rsp_window_average       <= avg_in;
         rsp_drift_from_reference <= {1'b0, avg_in} - {1'b0, ref_in};
         rsp_last_change          <= trk2_ff.change;
         rsp_lowest_seen          <= trk2_ff.lowest;
         rsp_highest_seen         <= trk2_ff.highest;
      end
   end

   // The tracked floor never rises above the tracked peak.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lowest_seen <= rsp_highest_seen))
      else $error("lowest_seen above highest_seen");

   // Usage above the danger threshold must grade as danger.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_usage_bytes > danger_ff)) |-> (rsp_alarm_level == LEVEL_DANGER))
      else $error("danger usage not graded as danger");

   // Usage is the distance from the peak, so it can never exceed the peak.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_usage_bytes <= rsp_highest_seen))
      else $error("usage exceeds highest_seen");

endmodule
`default_nettype wire
